### design/sag_pkg.sv
// Shared constants, types and helpers of the strided N-dimensional address generator.
package sag_pkg;

  // Field and register widths
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned EXT_W      = 16;
  localparam int unsigned STRIDE_W   = 32;
  localparam int unsigned ACTIVE_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // Number of axes that have extent and stride registers
  localparam int unsigned REG_AXES = 3;

  // Default parameter values
  localparam int unsigned NUM_AXES_DEF    = 3;
  localparam int unsigned EXTENT_BITS_DEF = 16;

  // Cycles the derived limit and jump offsets need after a register write
  localparam int unsigned SETTLE_W      = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_AXES  = 3'd0,
    CFG_BASE_ADDRESS = 3'd1,
    CFG_EXTENT0      = 3'd2,
    CFG_EXTENT1      = 3'd3,
    CFG_EXTENT2      = 3'd4,
    CFG_STRIDE0      = 3'd5,
    CFG_STRIDE1      = 3'd6,
    CFG_STRIDE2      = 3'd7
  } cfg_reg_e;

  // One result item
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              more;
    logic [ADDR_W-1:0] element_index;
  } result_t;

  // Number of axes actually walked: the register clamped to the built axes
  function automatic logic [ACTIVE_W-1:0] used_axes(input logic [ACTIVE_W-1:0] active,
                                                    input int unsigned live);
    logic [ACTIVE_W-1:0] n;
    n = active;
    if (int'(active) > int'(live)) begin
      n = ACTIVE_W'(live);
    end
    return n;
  endfunction

endpackage

### design/sag_cfg_prep.sv
// Two-stage pipeline that derives the element limit and per-axis jump offsets from the registers.
module sag_cfg_prep #(
  parameter int unsigned NUM_AXES    = sag_pkg::NUM_AXES_DEF,
  parameter int unsigned EXTENT_BITS = sag_pkg::EXTENT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic [sag_pkg::ACTIVE_W-1:0]         active_axes_i,
  input  logic [sag_pkg::EXT_W-1:0]            extent_i [sag_pkg::REG_AXES],
  input  logic [sag_pkg::STRIDE_W-1:0]         stride_i [sag_pkg::REG_AXES],
  output logic [sag_pkg::ADDR_W-1:0]           limit_o,
  output logic [sag_pkg::ADDR_W-1:0]           jump_o   [(NUM_AXES < sag_pkg::REG_AXES) ?
                                                         NUM_AXES : sag_pkg::REG_AXES],
  output logic [sag_pkg::ADDR_W-1:0]           jump_all_o
);

  localparam int unsigned LIVE   = (NUM_AXES < sag_pkg::REG_AXES) ? NUM_AXES : sag_pkg::REG_AXES;
  localparam int unsigned EW     = (EXTENT_BITS < sag_pkg::EXT_W) ? EXTENT_BITS : sag_pkg::EXT_W;
  localparam int unsigned PROD_W = sag_pkg::STRIDE_W + EW + 1;
  localparam int unsigned AW     = sag_pkg::ADDR_W;
  localparam int unsigned RA     = sag_pkg::REG_AXES;

  logic [sag_pkg::ACTIVE_W-1:0] n_used;
  logic [EW-1:0]                factor   [RA];
  logic [AW-1:0]                back_d   [RA];
  logic [AW-1:0]                sx_d     [RA];
  logic [2*EW-1:0]              p01_d;

  logic [AW-1:0]                back_q   [RA];
  logic [AW-1:0]                sx_q     [RA];
  logic [2*EW-1:0]              p01_q;
  logic [EW-1:0]                f2_q;

  logic [AW-1:0]                limit_d;
  logic [AW-1:0]                jump_d   [RA];
  logic [AW-1:0]                jump_all_d;
  logic [AW-1:0]                limit_q;
  logic [AW-1:0]                jump_q   [RA];
  logic [AW-1:0]                jump_all_q;

  assign n_used = sag_pkg::used_axes(active_axes_i, LIVE);

  // Stage A: rewind offset of each axis, extent factors, first partial product
  always_comb begin
    logic [EW-1:0]            em;
    logic [EW-1:0]            em1;
    logic signed [PROD_W-1:0] prod;
    logic                     in_use;
    for (int a = 0; a < int'(RA); a++) begin
      em     = extent_i[a][EW-1:0];
      em1    = em - EW'(1);
      in_use = (a < int'(n_used));
      prod   = $signed(stride_i[a]) * $signed({1'b0, em1});
      factor[a] = in_use ? em : EW'(1);
      sx_d[a]   = in_use ? AW'($signed(stride_i[a])) : '0;
      back_d[a] = in_use ? (AW'(0) - AW'(prod)) : '0;
    end
    p01_d = {{EW{1'b0}}, factor[0]} * {{EW{1'b0}}, factor[1]};
  end

  always_ff @(posedge clk_i) begin
    back_q <= back_d;
    sx_q   <= sx_d;
    p01_q  <= p01_d;
    f2_q   <= factor[2];
  end

  // Stage B: full limit and suffix sums of rewind offsets
  always_comb begin
    logic [AW-1:0] acc;
    limit_d = AW'({{EW{1'b0}}, p01_q} * {{(2*EW){1'b0}}, f2_q});
    acc = '0;
    for (int a = int'(RA) - 1; a >= 0; a--) begin
      jump_d[a] = sx_q[a] + acc;
      acc       = acc + back_q[a];
    end
    jump_all_d = acc;
  end

  always_ff @(posedge clk_i) begin
    limit_q    <= limit_d;
    jump_q     <= jump_d;
    jump_all_q <= jump_all_d;
  end

  assign limit_o    = limit_q;
  assign jump_all_o = jump_all_q;
  always_comb begin
    for (int a = 0; a < int'(LIVE); a++) begin
      jump_o[a] = jump_q[a];
    end
  end

endmodule

### design/sag_out_skid.sv
// Result register with a skid entry so the input side keeps taking items under short stalls.
module sag_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sag_pkg::result_t data_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sag_pkg::result_t out_data_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  sag_pkg::result_t out_q;
  sag_pkg::result_t skid_q;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign ready_o  = !skid_valid_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/strided_nd_address_generator.sv
// Strided N-dimensional address generator: top level with registers, odometer state and output.
//
// One item per clock cycle while in_ready_o is high: every accepted item (advance or restart)
// gives one result, registered in a two-deep output stage whose skid entry lets the input keep
// going while the consumer stalls, until that entry is full. The element limit (product of
// active extents) and the address jump of each carry position are derived from the registers
// by a two-stage multiplier pipeline, so in_ready_o is held low after reset and after every
// register write. Each item takes one carry search over the axes and one 48-bit address add.
module strided_nd_address_generator #(
  parameter int unsigned NUM_AXES    = sag_pkg::NUM_AXES_DEF,
  parameter int unsigned EXTENT_BITS = sag_pkg::EXTENT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sag_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sag_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sag_pkg::ADDR_W-1:0]       address_o,
  output logic                             more_o,
  output logic [sag_pkg::ADDR_W-1:0]       element_index_o
);

  localparam int unsigned LIVE = (NUM_AXES < sag_pkg::REG_AXES) ? NUM_AXES : sag_pkg::REG_AXES;
  localparam int unsigned EW   = (EXTENT_BITS < sag_pkg::EXT_W) ? EXTENT_BITS : sag_pkg::EXT_W;
  localparam int unsigned AW   = sag_pkg::ADDR_W;
  localparam int unsigned RA   = sag_pkg::REG_AXES;

  // Configuration registers
  logic [sag_pkg::ACTIVE_W-1:0] active_q;
  logic [AW-1:0]                base_q;
  logic [sag_pkg::EXT_W-1:0]    ext_q    [RA];
  logic [sag_pkg::STRIDE_W-1:0] stride_q [RA];
  logic [sag_pkg::SETTLE_W-1:0] settle_q;

  // Walk state
  logic [EW-1:0]                pos_q    [LIVE];
  logic [EW-1:0]                pos_d    [LIVE];
  logic [AW-1:0]                addr_q;
  logic [AW-1:0]                addr_d;
  logic [AW-1:0]                count_q;
  logic [AW-1:0]                count_d;
  logic                         more_d;
  logic                         step_more;

  // Derived values
  logic [AW-1:0]                limit;
  logic [AW-1:0]                jump     [LIVE];
  logic [AW-1:0]                jump_all;
  logic [sag_pkg::ACTIVE_W-1:0] n_used;

  logic                         skid_ready;
  logic                         accept;
  sag_pkg::result_t             res_d;
  sag_pkg::result_t             res_out;

  // Register writes; each write restarts the settle count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= sag_pkg::ACTIVE_W'(3);
      base_q   <= '0;
      for (int a = 0; a < int'(RA); a++) begin
        ext_q[a]    <= sag_pkg::EXT_W'(1);
        stride_q[a] <= '0;
      end
      settle_q <= sag_pkg::SETTLE_CYCLES;
    end else begin
      if (cfg_we_i) begin
        settle_q <= sag_pkg::SETTLE_CYCLES;
        unique case (sag_pkg::cfg_reg_e'(cfg_index_i))
          sag_pkg::CFG_ACTIVE_AXES:  active_q    <= cfg_wdata_i[sag_pkg::ACTIVE_W-1:0];
          sag_pkg::CFG_BASE_ADDRESS: base_q      <= cfg_wdata_i[AW-1:0];
          sag_pkg::CFG_EXTENT0:      ext_q[0]    <= cfg_wdata_i[sag_pkg::EXT_W-1:0];
          sag_pkg::CFG_EXTENT1:      ext_q[1]    <= cfg_wdata_i[sag_pkg::EXT_W-1:0];
          sag_pkg::CFG_EXTENT2:      ext_q[2]    <= cfg_wdata_i[sag_pkg::EXT_W-1:0];
          sag_pkg::CFG_STRIDE0:      stride_q[0] <= cfg_wdata_i[sag_pkg::STRIDE_W-1:0];
          sag_pkg::CFG_STRIDE1:      stride_q[1] <= cfg_wdata_i[sag_pkg::STRIDE_W-1:0];
          sag_pkg::CFG_STRIDE2:      stride_q[2] <= cfg_wdata_i[sag_pkg::STRIDE_W-1:0];
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - sag_pkg::SETTLE_W'(1);
      end
    end
  end

  sag_cfg_prep #(
    .NUM_AXES    (NUM_AXES),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_prep (
    .clk_i         (clk_i),
    .active_axes_i (active_q),
    .extent_i      (ext_q),
    .stride_i      (stride_q),
    .limit_o       (limit),
    .jump_o        (jump),
    .jump_all_o    (jump_all)
  );

  assign n_used     = sag_pkg::used_axes(active_q, LIVE);
  assign in_ready_o = (settle_q == '0) && skid_ready;
  assign accept     = in_valid_i && in_ready_o;

  // Odometer step: the fastest axis that can still count up takes the carry
  always_comb begin
    logic          seen;
    logic [EW:0]   pos_inc;
    logic [EW:0]   ext_m;
    logic          inc_ok;
    logic [AW-1:0] step;
    seen      = 1'b0;
    step      = jump_all;
    count_d   = count_q + AW'(1);
    step_more = (count_d < limit);
    for (int a = int'(LIVE) - 1; a >= 0; a--) begin
      pos_inc = {1'b0, pos_q[a]} + (EW+1)'(1);
      ext_m   = {1'b0, ext_q[a][EW-1:0]};
      inc_ok  = (a < int'(n_used)) && (pos_inc < ext_m);
      pos_d[a] = pos_q[a];
      if (a < int'(n_used) && !seen) begin
        if (inc_ok) begin
          pos_d[a] = pos_inc[EW-1:0];
          step     = jump[a];
        end else begin
          pos_d[a] = '0;
        end
      end
      seen = seen || inc_ok;
    end
    addr_d = addr_q + step;
    more_d = step_more;
    if (restart_i) begin
      for (int a = 0; a < int'(LIVE); a++) begin
        pos_d[a] = '0;
      end
      addr_d  = base_q;
      count_d = '0;
      more_d  = (limit != '0);
    end else if (!step_more) begin
      pos_d  = pos_q;
      addr_d = addr_q;
    end
  end

  // Walk state update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < int'(LIVE); a++) begin
        pos_q[a] <= '0;
      end
      addr_q  <= '0;
      count_q <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      addr_q  <= addr_d;
      count_q <= count_d;
    end
  end

  // Result to the output stage
  assign res_d.address       = addr_d;
  assign res_d.more          = more_d;
  assign res_d.element_index = count_d;

  sag_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res_d),
    .ready_o     (skid_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res_out)
  );

  assign address_o       = res_out.address;
  assign more_o          = res_out.more;
  assign element_index_o = res_out.element_index;

  // Input held off while derived values settle after a write
  a_cfg_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("item accepted right after a register write");

  // Restart returns to the base address with the count cleared
  a_restart_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && restart_i) |=> (addr_q == $past(base_q)) && (count_q == '0))
    else $error("restart did not return to base");

  // Every advance raises the count by one
  a_advance_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !restart_i) |=> (count_q == $past(count_q) + AW'(1)))
    else $error("element count did not step by one");

  // Past the end the address holds
  a_finished_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !restart_i && !step_more) |=> $stable(addr_q))
    else $error("address moved after iteration finished");

endmodule
